// ----- design/gcbb_pkg.sv -----
// Package: beat types, function codes, register indexes and store/reciprocal constants of the glyph blend blitter.
`default_nettype none
package gcbb_pkg;

  // Default store depth in pixels (power of two)
  localparam int unsigned TARGET_PIXELS_DEF = 65536;

  // Function codes of an input beat
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BLEND = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_ROWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COLS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MAX      = 3'd6;

  // Reciprocal scaling: q = (n * ceil(2^RECIP_SHIFT / g)) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] pixel_address;
    logic [7:0]  pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic        wrote;
    logic [15:0] written_address;
    logic        glyph_done;
  } out_item_t;

endpackage
`default_nettype wire

// ----- design/glyph_coverage_blend_blit.sv -----
// Top level: glyph coverage blend blit into an 8-bit gray target store.
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+------------------------------
//  in       | in_valid  in_ready  in_data             | func, pixel_address, value
//  out      | out_valid out_ready out_data            | read_value, wrote, addr, done
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data  | register write, always ready
//
// One beat per cycle sustained unless a hazard or an output stall holds it. A beat passes S0
// (decode/address), S1 (store read), S2 (blend/write) and the output register. The store has
// one write and one read port; a read issuing while the beat just ahead still has its write
// to the same pixel in flight waits (e.g. back-to-back blends of a 1x1 glyph); a write on the same
// edge as the read is forwarded. Output stalls freeze the whole pipe; S0 still fills while empty.
// Reset is synchronous and clears control, counters and config registers; data and the store are not cleared.
`default_nettype none
module glyph_coverage_blend_blit #(
  parameter int unsigned TARGET_PIXELS = gcbb_pkg::TARGET_PIXELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire gcbb_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output gcbb_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gcbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcbb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gcbb_pkg::*;

  // TARGET_PIXELS is a power of two; address reduction is a truncation
  localparam int unsigned AW = $clog2(TARGET_PIXELS);
  localparam int unsigned CW = 19;  // py * width + px, full range

  // ---------------- reciprocal table, one entry per gray_max ----------------
  logic [RECIP_W-1:0] recip_tbl [256];
  assign recip_tbl[0] = '0;
  for (genvar gi = 1; gi < 256; gi++) begin : g_recip
    localparam logic [RECIP_W-1:0] RecipVal =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(gi) - 64'd1) / 64'(gi));
    assign recip_tbl[gi] = RecipVal;
  end

  // ---------------- configuration ----------------
  logic [8:0] target_width_r, target_height_r, glyph_rows_r, glyph_cols_r;
  logic [9:0] origin_x_r, origin_y_r;
  logic [7:0] gray_max_r;

  assign cfg_ready = 1'b1;

  // ---------------- glyph walk counters ----------------
  logic [7:0] row_counter_r, col_counter_r;
  logic [7:0] row_counter_nxt, col_counter_nxt;

  // ---------------- pipeline registers ----------------
  // S0: accepted beat, decoded
  logic        s0_valid_r;
  logic [1:0]  s0_func_r;
  logic [15:0] s0_in_addr_r;
  logic [7:0]  s0_val_r, s0_p_r, s0_g_r;
  logic        s0_inb_r, s0_done_r;
  logic [8:0]  s0_py_r, s0_px_r;
  // S1: store read data in flight
  logic          s1_valid_r;
  logic [1:0]    s1_func_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_we_r, s1_touch_r, s1_done_r;
  logic [7:0]    s1_val_r, s1_p_r, s1_g_r;
  logic [7:0]    rdata_r, fwd_data_r;
  logic          fwd_hit_r;
  // S2: scale by reciprocal, write back
  logic               s2_valid_r;
  logic [1:0]         s2_func_r;
  logic [AW-1:0]      s2_addr_r;
  logic               s2_we_r, s2_touch_r, s2_done_r;
  logic [7:0]         s2_val_r;
  logic [15:0]        s2_n_r;
  logic [RECIP_W-1:0] s2_m_r;
  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic [7:0] target_mem [TARGET_PIXELS];

  // ---------------- accept-side decode ----------------
  logic              accept;
  logic signed [10:0] py, px;
  logic              inb;
  logic [7:0]        g_eff, p_eff;
  logic [8:0]        rows_eff, cols_eff;
  logic              col_last, row_last;

  assign accept = in_valid && in_ready;

  always_comb begin
    py = $signed({origin_y_r[9], origin_y_r}) - $signed({3'b000, row_counter_r});
    px = $signed({origin_x_r[9], origin_x_r}) + $signed({3'b000, col_counter_r});
    inb = !py[10] && !px[10] &&
          (py[9:0] < {1'b0, target_height_r}) && (px[9:0] < {1'b0, target_width_r});
    g_eff = (gray_max_r == 8'd0) ? 8'd1 : gray_max_r;
    p_eff = (in_data.pixel_value > g_eff) ? g_eff : in_data.pixel_value;
    rows_eff = (glyph_rows_r == 9'd0) ? 9'd1 :
               (glyph_rows_r > 9'd256) ? 9'd256 : glyph_rows_r;
    cols_eff = (glyph_cols_r == 9'd0) ? 9'd1 :
               (glyph_cols_r > 9'd256) ? 9'd256 : glyph_cols_r;
    col_last = ({1'b0, col_counter_r} + 9'd1) >= cols_eff;
    row_last = ({1'b0, row_counter_r} + 9'd1) >= rows_eff;
    row_counter_nxt = row_counter_r;
    col_counter_nxt = col_counter_r;
    if (accept && in_data.func == FUNC_BLEND) begin
      if (col_last) begin
        col_counter_nxt = 8'd0;
        row_counter_nxt = row_last ? 8'd0 : row_counter_r + 8'd1;
      end else begin
        col_counter_nxt = col_counter_r + 8'd1;
      end
    end
  end

  // ---------------- S0 combinational: address and hazard ----------------
  logic [17:0]   row_base;
  logic [CW-1:0] blit_addr;
  logic [AW-1:0] s0_addr;
  logic          s0_is_blend, s0_we, s0_touch, s0_need_rd;
  logic          hazard, adv, s0_go;

  always_comb begin
    row_base    = s0_py_r * target_width_r;
    blit_addr   = {1'b0, row_base} + {10'b0, s0_px_r};
    s0_is_blend = (s0_func_r == FUNC_BLEND);
    s0_addr     = s0_is_blend ? AW'(blit_addr) : AW'(s0_in_addr_r);
    s0_we       = (s0_func_r == FUNC_LOAD) || (s0_is_blend && s0_inb_r);
    s0_touch    = s0_we || (s0_func_r == FUNC_READ);
    s0_need_rd  = (s0_func_r == FUNC_READ) || (s0_is_blend && s0_inb_r);
  end

  // the beat one stage ahead would write this pixel after our read issues
  assign hazard = s0_valid_r && s0_need_rd && s1_valid_r && s1_we_r &&
                  (s1_addr_r == s0_addr);
  assign adv    = !out_valid_r || out_ready;
  assign s0_go  = adv && !hazard;
  assign in_ready = !s0_valid_r || s0_go;

  // ---------------- S1 combinational: blend numerator ----------------
  logic [7:0]  dst;
  logic [15:0] num;

  always_comb begin
    dst = fwd_hit_r ? fwd_data_r : rdata_r;
    num = ({s1_p_r, 8'd0} - {8'd0, s1_p_r}) + (16'(s1_g_r - s1_p_r) * 16'(dst));
  end

  // ---------------- S2 combinational: quotient and write data ----------------
  logic [15+RECIP_W:0] quot_prod;
  logic [7:0]          quot, wdata, rvalue;
  logic                mem_we;

  always_comb begin
    quot_prod = s2_n_r * s2_m_r;
    quot      = quot_prod[RECIP_SHIFT +: 8];
    wdata     = (s2_func_r == FUNC_BLEND) ? quot : s2_val_r;
    rvalue    = s2_touch_r ? wdata : 8'd0;
    mem_we    = adv && s2_valid_r && s2_we_r;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_width_r  <= 9'd256;
      target_height_r <= 9'd256;
      origin_x_r      <= 10'd0;
      origin_y_r      <= 10'd0;
      glyph_rows_r    <= 9'd1;
      glyph_cols_r    <= 9'd1;
      gray_max_r      <= 8'd255;
      row_counter_r   <= 8'd0;
      col_counter_r   <= 8'd0;
      s0_valid_r      <= 1'b0;
      s1_valid_r      <= 1'b0;
      s2_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TARGET_WIDTH:  target_width_r  <= cfg_data[8:0];
          CFG_TARGET_HEIGHT: target_height_r <= cfg_data[8:0];
          CFG_ORIGIN_X:      origin_x_r      <= cfg_data;
          CFG_ORIGIN_Y:      origin_y_r      <= cfg_data;
          CFG_GLYPH_ROWS:    glyph_rows_r    <= cfg_data[8:0];
          CFG_GLYPH_COLS:    glyph_cols_r    <= cfg_data[8:0];
          CFG_GRAY_MAX:      gray_max_r      <= cfg_data[7:0];
          default: ;
        endcase
      end
      row_counter_r <= row_counter_nxt;
      col_counter_r <= col_counter_nxt;
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (adv) begin
        s1_valid_r  <= s0_valid_r && !hazard;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_func_r    <= in_data.func;
      s0_in_addr_r <= in_data.pixel_address;
      s0_val_r     <= in_data.pixel_value;
      s0_p_r       <= p_eff;
      s0_g_r       <= g_eff;
      s0_inb_r     <= inb;
      s0_py_r      <= py[8:0];
      s0_px_r      <= px[8:0];
      s0_done_r    <= (in_data.func == FUNC_BLEND) && col_last && row_last;
    end
    if (s0_go) begin
      s1_func_r  <= s0_func_r;
      s1_addr_r  <= s0_addr;
      s1_we_r    <= s0_we;
      s1_touch_r <= s0_touch;
      s1_done_r  <= s0_done_r;
      s1_val_r   <= s0_val_r;
      s1_p_r     <= s0_p_r;
      s1_g_r     <= s0_g_r;
      // write on this same edge is not seen by the array read
      fwd_hit_r  <= mem_we && (s2_addr_r == s0_addr);
      fwd_data_r <= wdata;
    end
    if (adv) begin
      s2_func_r  <= s1_func_r;
      s2_addr_r  <= s1_addr_r;
      s2_we_r    <= s1_we_r;
      s2_touch_r <= s1_touch_r;
      s2_done_r  <= s1_done_r;
      s2_val_r   <= (s1_func_r == FUNC_READ) ? dst : s1_val_r;
      s2_n_r     <= num;
      s2_m_r     <= recip_tbl[s1_g_r];
      if (s2_valid_r) begin
        out_data_r.read_value      <= rvalue;
        out_data_r.wrote           <= s2_we_r;
        out_data_r.written_address <= s2_touch_r ? 16'(s2_addr_r) : 16'd0;
        out_data_r.glyph_done      <= s2_done_r;
      end
    end
  end

  // ---------------- target store ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      target_mem[s2_addr_r] <= wdata;
    end
    if (s0_go) begin
      rdata_r <= target_mem[s0_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  // a read stalled behind a pending write leaves a bubble in S1
  a_hazard_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    hazard && adv |=> !s1_valid_r)
    else $error("hazard did not insert a bubble");

  // only loads and in-bounds blends reach the store write port
  a_write_func: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_we_r |-> (s2_func_r == FUNC_LOAD) || (s2_func_r == FUNC_BLEND))
    else $error("store write from a non-writing function");

  // glyph end is flagged only on blend beats
  a_done_blend: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_done_r |-> s2_func_r == FUNC_BLEND)
    else $error("glyph_done on a non-blend beat");

endmodule
`default_nettype wire
